// ----- sv/frba_pkg.sv -----
// Shared types and constants for the fenced ring buffer allocator.
`default_nettype none

package frba_pkg;

   // Field widths fixed by the beat formats.
   localparam int OFFSET_BITS    = 24;
   localparam int SIZE_BITS      = OFFSET_BITS + 1;
   localparam int ALIGN_BITS     = 17;
   localparam int FENCE_BITS     = 64;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [SIZE_BITS-1:0] RING_MAX = SIZE_BITS'(1) << OFFSET_BITS;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RING_SIZE       = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLUSH_THRESHOLD = CSR_INDEX_BITS'(1);

   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_QUEUE   = 2'd1,
      OP_FENCE   = 2'd2,
      OP_NOP     = 2'd3
   } frba_op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_ALIGN   = 3'd1,
      ST_ZERO_SIZE   = 3'd2,
      ST_TOO_BIG     = 3'd3,
      ST_FULL        = 3'd4,
      ST_HEAD_OVERRUN = 3'd5,
      ST_STORE_FULL  = 3'd6
   } frba_status_type;

   typedef struct packed {
      frba_op_type           op;
      logic [SIZE_BITS-1:0]  request_size;
      logic [ALIGN_BITS-1:0] alignment;
      logic [FENCE_BITS-1:0] fence_value;
   } frba_req_type;

   typedef struct packed {
      frba_status_type        status;
      logic [OFFSET_BITS-1:0] region_offset;
      logic [SIZE_BITS-1:0]   region_size;
      logic                   flush_needed;
      logic [SIZE_BITS-1:0]   used_bytes;
   } frba_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic res_align;
      logic res_cost;
      logic res_commit;
      logic res_reply;
      logic queue_reply;
      logic fence_eval;
      logic fence_apply;
      logic plain_reply;
   } frba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fence_hit;
   } frba_stat_type;

endpackage

`default_nettype wire

// ----- sv/frba_datapath.sv -----
// Datapath of the fenced ring buffer allocator: ring state, checkpoint memory, arithmetic.
`default_nettype none

module frba_datapath #(
   parameter int CHECKPOINT_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  frba_pkg::frba_req_type                 req_data,
   input  logic                                   csr_we,
   input  logic [frba_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [frba_pkg::SIZE_BITS-1:0]         csr_data,
   input  frba_pkg::frba_cmd_type                 cmd,
   output frba_pkg::frba_stat_type                stat,
   output frba_pkg::frba_rsp_type                 rsp_data
);

   import frba_pkg::*;

   localparam int CALC_BITS = SIZE_BITS + 1;
   localparam int SUM_BITS  = SIZE_BITS + 2;
   localparam int PTR_BITS  = $clog2(CHECKPOINT_DEPTH);
   localparam int CNT_BITS  = $clog2(CHECKPOINT_DEPTH + 1);
   localparam logic [CNT_BITS-1:0]   CNT_FULL   = CNT_BITS'(CHECKPOINT_DEPTH);
   localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(CHECKPOINT_DEPTH - 1);
   localparam logic [PTR_BITS:0]     DEPTH_WIDE = (PTR_BITS + 1)'(CHECKPOINT_DEPTH);
   localparam logic [SIZE_BITS-1:0]  SIZE_ALL   = '1;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  tail;
      logic [FENCE_BITS-1:0] fence;
   } ckpt_type;

   // Ring state and configuration.
   logic [SIZE_BITS-1:0]  ring_ff, flush_ff, head_ff, tail_ff, used_ff, unc_ff;
   logic [PTR_BITS-1:0]   first_ff;
   logic [CNT_BITS-1:0]   count_ff;

   // Latched request.
   logic [SIZE_BITS-1:0]  size_ff;
   logic [ALIGN_BITS-1:0] align_ff;
   logic [FENCE_BITS-1:0] fence_ff;

   // Reserve intermediates.
   logic [CALC_BITS-1:0]  atail_ff, sz_ff, cost_ff;
   logic [SUM_BITS-1:0]   end_ff;
   logic                  wrap_ff;
   logic [SIZE_BITS-1:0]  off_ff;
   frba_status_type       code_ff;

   // Fence intermediates.
   logic [CALC_BITS-1:0]  delta_ff;
   logic                  same_ff;

   ckpt_type              ckpt_mem [CHECKPOINT_DEPTH];
   ckpt_type              rd_ff;
   frba_rsp_type          rsp_ff;

   logic [CALC_BITS-1:0]  align_m1, atail_calc, sz_calc, cost_calc;
   logic                  align_bad;
   logic [SUM_BITS-1:0]   end_calc, used_sum, unc_sum;
   logic                  wrap_calc, full_calc, overrun_calc, commit;
   logic [SIZE_BITS-1:0]  room, unc_next, thr, ring_clamp, head_room;
   logic [PTR_BITS:0]     slot_sum;
   logic [PTR_BITS-1:0]   wslot;
   logic                  queue_pending, queue_do;
   logic [CALC_BITS-1:0]  delta_calc;

   always_comb begin
      align_m1   = CALC_BITS'(align_ff) - CALC_BITS'(1);
      align_bad  = (align_ff == '0) || ((align_ff & (align_ff - ALIGN_BITS'(1))) != '0);
      atail_calc = (CALC_BITS'(tail_ff) + align_m1) & ~align_m1;
      sz_calc    = (CALC_BITS'(size_ff) + align_m1) & ~align_m1;

      end_calc  = SUM_BITS'(atail_ff) + SUM_BITS'(sz_ff);
      wrap_calc = end_calc > SUM_BITS'(ring_ff);
      room      = (ring_ff > tail_ff) ? (ring_ff - tail_ff) : '0;
      cost_calc = wrap_calc ? (CALC_BITS'(room) + sz_ff)
                            : (atail_ff - CALC_BITS'(tail_ff) + sz_ff);

      used_sum     = SUM_BITS'(used_ff) + SUM_BITS'(cost_ff);
      full_calc    = used_sum > SUM_BITS'(ring_ff);
      overrun_calc = (atail_ff < CALC_BITS'(head_ff)) &&
                     (wrap_ff || (end_ff > SUM_BITS'(head_ff)));
      commit       = (code_ff == ST_OK) && !full_calc && !overrun_calc;
      unc_sum      = SUM_BITS'(unc_ff) + SUM_BITS'(cost_ff);
      unc_next     = (unc_sum > SUM_BITS'(SIZE_ALL)) ? SIZE_ALL : unc_sum[SIZE_BITS-1:0];

      thr = (flush_ff > ring_ff) ? ring_ff : flush_ff;

      ring_clamp = (csr_data == '0)     ? SIZE_BITS'(1) :
                   (csr_data > RING_MAX) ? RING_MAX      : csr_data;

      // Next free slot wraps at the depth, which need not be a power of two.
      slot_sum      = (PTR_BITS + 1)'(first_ff) + (PTR_BITS + 1)'(count_ff);
      wslot         = (slot_sum >= DEPTH_WIDE) ? PTR_BITS'(slot_sum - DEPTH_WIDE)
                                               : PTR_BITS'(slot_sum);
      queue_pending = cmd.queue_reply && (unc_ff != '0);
      queue_do      = queue_pending && (count_ff != CNT_FULL);

      // Bytes freed when the head moves to the checkpoint's tail.
      head_room  = (ring_ff > head_ff) ? (ring_ff - head_ff) : '0;
      delta_calc = (rd_ff.tail > head_ff) ? CALC_BITS'(rd_ff.tail - head_ff)
                                          : CALC_BITS'(head_room) + CALC_BITS'(rd_ff.tail);

      stat.fence_hit = (count_ff != '0) && (fence_ff >= rd_ff.fence);
   end

   // Control state of the ring.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff  <= RING_MAX;
         flush_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         used_ff  <= '0;
         unc_ff   <= '0;
         first_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_we && (csr_index == CSR_RING_SIZE)) begin
            ring_ff <= ring_clamp;
            head_ff <= '0;
            tail_ff <= '0;
            used_ff <= '0;
            unc_ff  <= '0;
         end else if (csr_we && (csr_index == CSR_FLUSH_THRESHOLD)) begin
            flush_ff <= csr_data;
         end else if (cmd.res_commit && commit) begin
            used_ff <= used_sum[SIZE_BITS-1:0];
            unc_ff  <= unc_next;
            tail_ff <= wrap_ff ? sz_ff[SIZE_BITS-1:0] : end_ff[SIZE_BITS-1:0];
         end else if (queue_do) begin
            count_ff <= count_ff + CNT_BITS'(1);
            unc_ff   <= '0;
         end else if (cmd.fence_apply) begin
            if (same_ff) begin
               used_ff <= '0;
            end else begin
               used_ff <= (CALC_BITS'(used_ff) > delta_ff)
                          ? (used_ff - delta_ff[SIZE_BITS-1:0]) : '0;
            end
            head_ff  <= rd_ff.tail;
            first_ff <= (first_ff == PTR_LAST) ? '0 : (first_ff + PTR_BITS'(1));
            count_ff <= count_ff - CNT_BITS'(1);
         end
      end
   end

   // Request latch and reserve pipeline registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         size_ff  <= req_data.request_size;
         align_ff <= req_data.alignment;
         fence_ff <= req_data.fence_value;
      end
      if (cmd.res_align) begin
         atail_ff <= atail_calc;
         sz_ff    <= sz_calc;
         if (align_bad) begin
            code_ff <= ST_BAD_ALIGN;
         end else if (size_ff == '0) begin
            code_ff <= ST_ZERO_SIZE;
         end else begin
            code_ff <= ST_OK;
         end
      end
      if (cmd.res_cost) begin
         end_ff  <= end_calc;
         wrap_ff <= wrap_calc;
         cost_ff <= cost_calc;
         if ((code_ff == ST_OK) && (sz_ff > CALC_BITS'(ring_ff))) begin
            code_ff <= ST_TOO_BIG;
         end
      end
      if (cmd.res_commit) begin
         off_ff <= wrap_ff ? '0 : atail_ff[SIZE_BITS-1:0];
         if (code_ff == ST_OK) begin
            if (full_calc) begin
               code_ff <= ST_FULL;
            end else if (overrun_calc) begin
               code_ff <= ST_HEAD_OVERRUN;
            end
         end
      end
      if (cmd.fence_eval) begin
         same_ff  <= rd_ff.tail == head_ff;
         delta_ff <= delta_calc;
      end
   end

   // Checkpoint memory: one write port, one registered read at the oldest entry.
   always_ff @(posedge clock) begin
      if (queue_do) begin
         ckpt_mem[wslot] <= '{tail: tail_ff, fence: fence_ff};
      end
      rd_ff <= ckpt_mem[first_ff];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.res_reply) begin
         rsp_ff.status        <= code_ff;
         rsp_ff.region_offset <= (code_ff == ST_OK) ? off_ff[OFFSET_BITS-1:0] : '0;
         rsp_ff.region_size   <= (code_ff == ST_OK) ? sz_ff[SIZE_BITS-1:0] : '0;
         rsp_ff.flush_needed  <= (code_ff == ST_OK) && (unc_ff > thr);
         rsp_ff.used_bytes    <= used_ff;
      end else if (cmd.queue_reply || cmd.plain_reply) begin
         rsp_ff.status        <= (queue_pending && !queue_do) ? ST_STORE_FULL : ST_OK;
         rsp_ff.region_offset <= '0;
         rsp_ff.region_size   <= '0;
         rsp_ff.flush_needed  <= 1'b0;
         rsp_ff.used_bytes    <= used_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- sv/frba_controller.sv -----
// Controller state machine of the fenced ring buffer allocator.
`default_nettype none

module frba_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  frba_pkg::frba_op_type   req_op,
   input  frba_pkg::frba_stat_type stat,
   output frba_pkg::frba_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   import frba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RES_ALIGN,
      S_RES_COST,
      S_RES_COMMIT,
      S_RES_REPLY,
      S_QUEUE,
      S_NOP,
      S_FENCE_READ,
      S_FENCE_EVAL,
      S_FENCE_APPLY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_op)
                  OP_RESERVE: state_in = S_RES_ALIGN;
                  OP_QUEUE:   state_in = S_QUEUE;
                  OP_FENCE:   state_in = S_FENCE_READ;
                  OP_NOP:     state_in = S_NOP;
                  default:    state_in = S_NOP;
               endcase
            end
         end
         S_RES_ALIGN: begin
            cmd.res_align = 1'b1;
            state_in      = S_RES_COST;
         end
         S_RES_COST: begin
            cmd.res_cost = 1'b1;
            state_in     = S_RES_COMMIT;
         end
         S_RES_COMMIT: begin
            cmd.res_commit = 1'b1;
            state_in       = S_RES_REPLY;
         end
         S_RES_REPLY: begin
            cmd.res_reply = 1'b1;
            state_in      = S_IDLE;
         end
         S_QUEUE: begin
            cmd.queue_reply = 1'b1;
            state_in        = S_IDLE;
         end
         S_NOP: begin
            cmd.plain_reply = 1'b1;
            state_in        = S_IDLE;
         end
         S_FENCE_READ: begin
            state_in = S_FENCE_EVAL;
         end
         S_FENCE_EVAL: begin
            if (stat.fence_hit) begin
               cmd.fence_eval = 1'b1;
               state_in       = S_FENCE_APPLY;
            end else begin
               cmd.plain_reply = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_FENCE_APPLY: begin
            cmd.fence_apply = 1'b1;
            state_in        = S_FENCE_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.res_reply || cmd.queue_reply || cmd.plain_reply;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- sv/fenced_ring_buffer_allocator.sv -----
// Top level of the fenced ring buffer allocator: controller plus datapath.
// A reserve beat steps through alignment, cost, commit and reply states; a queue or no-op
// beat replies directly, and a fence beat reads, checks and applies each checkpoint retired.
// Throughput: one beat at a time; the next beat may be accepted in the cycle its result
// shows. Fence cost is set by the single registered read port of the checkpoint memory.
// Reset clears ring state and the checkpoint queue at once; the result strobe cannot be
// stalled by the receiver, so no result is ever held.
`default_nettype none

module fenced_ring_buffer_allocator #(
   parameter int CHECKPOINT_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                start,
   output logic                                busy,
   input  frba_pkg::frba_req_type              req_data,
   // Result channel.
   output logic                                rsp_valid,
   output frba_pkg::frba_rsp_type              rsp_data,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [frba_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [frba_pkg::SIZE_BITS-1:0]      csr_data
);

   import frba_pkg::*;

   frba_cmd_type  cmd;
   frba_stat_type stat;
   logic          csr_we;

   // Configuration writes are registered directly, so the channel is always ready.
   // The user's writes must arrive only while the block is idle, which keeps them clear
   // of the datapath's own ring state updates; the block itself does not enforce this.
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // The controller sequences each beat: a reserve walks alignment, cost, commit and
   // reply stages; a fence loops over the oldest checkpoint until one is newer than
   // the completed fence or the queue runs empty.
   frba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_data.op),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds head, tail, the byte counts, the configuration registers and
   // the checkpoint memory, and builds each result beat.
   frba_datapath #(
      .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- dv/frba_checker.sv -----
// Checker for the fenced ring buffer allocator: tracks allocator state and checks result beats.

module frba_checker #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  frba_pkg::frba_req_type              req_data,
   input  logic                                rsp_valid,
   input  frba_pkg::frba_rsp_type              rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [frba_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [frba_pkg::SIZE_BITS-1:0]      csr_data,
   output int                                  mismatches,
   output int                                  waiting
);

   import frba_pkg::*;

   localparam logic [63:0] COUNT_MAX = (64'd1 << SIZE_BITS) - 64'd1;

   logic [SIZE_BITS-1:0]  ring_bytes, flush_level, head, tail, used, open_bytes;
   logic [SIZE_BITS-1:0]  mark_tail [DEPTH];
   logic [FENCE_BITS-1:0] mark_fence [DEPTH];
   int                    mark_first, mark_count;
   frba_rsp_type          due_rsp [$];

   function automatic logic [63:0] floor_sub(input logic [63:0] a, input logic [63:0] b);
      return (a > b) ? a - b : 64'd0;
   endfunction

   // Applies one request beat to the tracked state and returns the result it must give.
   function automatic frba_rsp_type allocator_outcome(input frba_req_type r);
      frba_rsp_type o;
      logic [63:0]  a, atail, sz, cost, off, cap, ft, open_sum;
      logic         wrap;
      int           slot;
      o = '0;
      o.status = ST_OK;
      case (r.op)
         OP_RESERVE: begin
            a     = 64'(r.alignment);
            atail = (64'(tail) + a - 64'd1) & ~(a - 64'd1);
            sz    = (64'(r.request_size) + a - 64'd1) & ~(a - 64'd1);
            wrap  = (atail + sz > 64'(ring_bytes));
            cost  = wrap ? floor_sub(64'(ring_bytes), 64'(tail)) + sz
                         : atail - 64'(tail) + sz;
            if (a == 64'd0 || (a & (a - 64'd1)) != 64'd0)
               o.status = ST_BAD_ALIGN;
            else if (r.request_size == '0)
               o.status = ST_ZERO_SIZE;
            else if (sz > 64'(ring_bytes))
               o.status = ST_TOO_BIG;
            else if (64'(used) + cost > 64'(ring_bytes))
               o.status = ST_FULL;
            else if (atail < 64'(head) && (wrap || atail + sz > 64'(head)))
               o.status = ST_HEAD_OVERRUN;
            else begin
               off        = wrap ? 64'd0 : atail;
               used       = SIZE_BITS'(64'(used) + cost);
               open_sum   = 64'(open_bytes) + cost;
               open_bytes = (open_sum > COUNT_MAX) ? SIZE_BITS'(COUNT_MAX)
                                                   : SIZE_BITS'(open_sum);
               tail       = SIZE_BITS'(off + sz);
               cap        = (flush_level > ring_bytes) ? 64'(ring_bytes) : 64'(flush_level);
               o.region_offset = off[OFFSET_BITS-1:0];
               o.region_size   = sz[SIZE_BITS-1:0];
               o.flush_needed  = (64'(open_bytes) > cap);
            end
         end
         OP_QUEUE: begin
            if (open_bytes != '0) begin
               if (mark_count >= DEPTH)
                  o.status = ST_STORE_FULL;
               else begin
                  slot = (mark_first + mark_count) % DEPTH;
                  mark_tail[slot]  = tail;
                  mark_fence[slot] = r.fence_value;
                  mark_count++;
                  open_bytes = '0;
               end
            end
         end
         OP_FENCE: begin
            // Oldest checkpoints retire first; the head jumps to each retired tail.
            while (mark_count != 0 && r.fence_value >= mark_fence[mark_first]) begin
               ft = 64'(mark_tail[mark_first]);
               if (ft == 64'(head))
                  used = '0;
               else if (ft > 64'(head))
                  used = SIZE_BITS'(floor_sub(64'(used), ft - 64'(head)));
               else
                  used = SIZE_BITS'(floor_sub(64'(used),
                                              floor_sub(64'(ring_bytes), 64'(head)) + ft));
               head       = SIZE_BITS'(ft);
               mark_first = (mark_first + 1) % DEPTH;
               mark_count--;
            end
         end
         default: ;
      endcase
      o.used_bytes = used;
      return o;
   endfunction

   function automatic void apply_csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [SIZE_BITS-1:0] value);
      if (idx == CSR_RING_SIZE) begin
         ring_bytes = (value == '0) ? SIZE_BITS'(1) : ((value > RING_MAX) ? RING_MAX : value);
         head       = '0;
         tail       = '0;
         used       = '0;
         open_bytes = '0;
      end else if (idx == CSR_FLUSH_THRESHOLD) begin
         flush_level = value;
      end
   endfunction

   function automatic int field_differs(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
      if (want === got)
         return 0;
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      frba_rsp_type want;
      if (reset) begin
         ring_bytes  = RING_MAX;
         flush_level = '0;
         head        = '0;
         tail        = '0;
         used        = '0;
         open_bytes  = '0;
         mark_first  = 0;
         mark_count  = 0;
         due_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (due_rsp.size() == 0) begin
               $error("result beat with no request outstanding");
               mismatches++;
            end else begin
               want = due_rsp[0];
               due_rsp.delete(0);
               mismatches += field_differs("status", want.status, rsp_data.status);
               mismatches += field_differs("region_offset", want.region_offset,
                                           rsp_data.region_offset);
               mismatches += field_differs("region_size", want.region_size,
                                           rsp_data.region_size);
               mismatches += field_differs("flush_needed", want.flush_needed,
                                           rsp_data.flush_needed);
               mismatches += field_differs("used_bytes", want.used_bytes, rsp_data.used_bytes);
            end
         end
         if (start && !busy)
            due_rsp.push_back(allocator_outcome(req_data));
         if (csr_valid && csr_ready)
            apply_csr_write(csr_index, csr_data);
      end
      waiting <= due_rsp.size();
   end

endmodule

// ----- dv/tb_fenced_ring_buffer_allocator.sv -----
// Testbench top for the fenced ring buffer allocator: stimulus, watchdog and verdict.

module tb_fenced_ring_buffer_allocator;

   import frba_pkg::*;

   localparam int CHECKPOINT_DEPTH = 16;
   localparam int ITEM_GOAL        = 1700;
   localparam int PHASES           = 12;
   // Longest legal silence is a full checkpoint sweep plus a sender gap; this is far above it.
   localparam int QUIET_LIMIT      = 4000;
   // Index 3 maps to no register; a write there must leave the allocator untouched.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = CSR_INDEX_BITS'(3);

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   frba_req_type              req_data;
   logic                      rsp_valid;
   frba_rsp_type              rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [SIZE_BITS-1:0]      csr_data;

   int                        mismatches;
   int                        waiting;
   int                        quiet_cycles = 0;
   int                        sent_items = 0;
   int                        phase;
   int                        roll;
   logic                      calm = 1'b0;
   logic                      hoard;
   logic [SIZE_BITS-1:0]      ring_now, ring_req, span;
   logic [ALIGN_BITS-1:0]     align;
   logic [FENCE_BITS-1:0]     fence_queued, fence_done, fence_pick;

   fenced_ring_buffer_allocator #(
      .CHECKPOINT_DEPTH(CHECKPOINT_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   frba_checker #(
      .DEPTH(CHECKPOINT_DEPTH)
   ) u_grant_check (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mismatches(mismatches),
      .waiting   (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The watchdog restarts on any beat on any channel. A long silence means the
   // allocator has hung, so the run ends with a failure.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("fenced_ring_buffer_allocator: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one request beat. Inputs move on the falling edge; acceptance is seen at the
   // rising edge where start is high and busy is low. Once the allocator is free again,
   // outside calm stretches the sender keeps start low while a draw of 0 to 99 falls below 16.
   task automatic issue(input frba_op_type op, input logic [SIZE_BITS-1:0] size,
                        input logic [ALIGN_BITS-1:0] alignment,
                        input logic [FENCE_BITS-1:0] fence);
      frba_req_type beat;
      beat.op           = op;
      beat.request_size = size;
      beat.alignment    = alignment;
      beat.fence_value  = fence;
      @(negedge clock);
      start <= 1'b0;
      while (busy)
         @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 16)
         @(negedge clock);
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      if (op != OP_NOP)
         sent_items++;
   endtask

   // Drops start and holds off until every issued beat has produced its result.
   // The checker's outstanding count is read on the falling edge, after it has settled.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (waiting != 0)
         @(negedge clock);
   endtask

   // Register writes happen only while the allocator is idle, so the caller settles first.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [SIZE_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset ring of full size and a zero threshold.
      // Malformed reserves: zero size, zero alignment, alignment that is not a power of
      // two, and a request larger than the whole ring.
      issue(OP_RESERVE, '0, ALIGN_BITS'(1), '0);
      issue(OP_RESERVE, SIZE_BITS'(1), '0, '0);
      issue(OP_RESERVE, SIZE_BITS'(1), ALIGN_BITS'(3), '0);
      issue(OP_RESERVE, '1, ALIGN_BITS'(1), '1);
      // Take the whole ring at the widest alignment, then one byte more is refused as full.
      issue(OP_RESERVE, RING_MAX, ALIGN_BITS'(65536), '0);
      issue(OP_RESERVE, SIZE_BITS'(1), ALIGN_BITS'(1), '0);
      // The second queue signal finds nothing uncommitted and stores no checkpoint.
      issue(OP_QUEUE, '0, '0, FENCE_BITS'(5));
      issue(OP_QUEUE, '0, '0, FENCE_BITS'(6));
      issue(OP_NOP, '1, '1, '1);
      // A fence below the checkpoint retires nothing; an equal one frees the whole ring.
      issue(OP_FENCE, '0, '0, FENCE_BITS'(4));
      issue(OP_FENCE, '0, '0, FENCE_BITS'(5));
      // The tail sits at the very end, so the next region wraps to offset zero.
      issue(OP_RESERVE, SIZE_BITS'(100), ALIGN_BITS'(1), '0);
      issue(OP_RESERVE, SIZE_BITS'(1), ALIGN_BITS'(65536), '0);
      issue(OP_QUEUE, '0, '0, '1);
      issue(OP_FENCE, '0, '0, '0);
      issue(OP_FENCE, '0, '0, '1);

      // A zero ring size clamps to one byte; the threshold is set to RING_MAX.
      settle();
      write_csr(CSR_RING_SIZE, '0);
      write_csr(CSR_FLUSH_THRESHOLD, RING_MAX);
      write_csr(CSR_SPARE, '1);
      issue(OP_RESERVE, SIZE_BITS'(1), ALIGN_BITS'(1), '0);
      issue(OP_RESERVE, SIZE_BITS'(1), ALIGN_BITS'(1), '0);
      issue(OP_RESERVE, SIZE_BITS'(2), ALIGN_BITS'(1), '0);

      // A checkpoint kept across a ring size write leaves a stale head ahead of the tail,
      // so a region that would run past that head is refused as a head overrun.
      settle();
      write_csr(CSR_RING_SIZE, SIZE_BITS'(4096));
      write_csr(CSR_FLUSH_THRESHOLD, '1);
      issue(OP_RESERVE, SIZE_BITS'(1000), ALIGN_BITS'(1), '0);
      issue(OP_QUEUE, '0, '0, FENCE_BITS'(10));
      settle();
      write_csr(CSR_RING_SIZE, SIZE_BITS'(4096));
      issue(OP_FENCE, '0, '0, FENCE_BITS'(10));
      issue(OP_RESERVE, SIZE_BITS'(2000), ALIGN_BITS'(1), '0);
      issue(OP_RESERVE, SIZE_BITS'(500), ALIGN_BITS'(1), '0);

      // Random part, in phases. Each phase starts idle and may change the ring size and
      // threshold; checkpoints carry over, which keeps stale heads in play.
      fence_queued = FENCE_BITS'(100);
      fence_done   = fence_queued;
      ring_now     = SIZE_BITS'(4096);
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase % 6)
            0:       ring_req = SIZE_BITS'($urandom_range(16, 512));
            1:       ring_req = SIZE_BITS'($urandom_range(1024, 65536));
            2:       ring_req = '0;
            3:       ring_req = SIZE_BITS'($urandom_range(65537, RING_MAX));
            4:       ring_req = '1;
            default: ring_req = RING_MAX;
         endcase
         if (phase % 4 != 3) begin
            write_csr(CSR_RING_SIZE, ring_req);
            ring_now = (ring_req == '0) ? SIZE_BITS'(1)
                                        : ((ring_req > RING_MAX) ? RING_MAX : ring_req);
         end
         case (phase % 4)
            0:       write_csr(CSR_FLUSH_THRESHOLD, '0);
            1:       write_csr(CSR_FLUSH_THRESHOLD, RING_MAX);
            2:       write_csr(CSR_FLUSH_THRESHOLD, '1);
            default: write_csr(CSR_FLUSH_THRESHOLD, SIZE_BITS'($urandom_range(0, ring_now)));
         endcase
         // Hoarding phases rarely complete fences and reserve in small pieces, so the
         // checkpoint store fills up.
         hoard = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            fence_queued = {$urandom, $urandom};
            fence_done   = fence_queued;
         end
         while (sent_items < ITEM_GOAL * (phase + 1) / PHASES) begin
            calm = (sent_items >= 600 && sent_items < 900);
            if (!calm && $urandom_range(0, 149) == 0)
               settle();
            roll = $urandom_range(0, 99);
            if (hoard && roll >= 75 && $urandom_range(0, 9) != 0)
               roll = 30;
            if (roll < 3) begin
               issue(OP_NOP, SIZE_BITS'($urandom), ALIGN_BITS'($urandom), {$urandom, $urandom});
            end else if (roll < 8) begin
               // Unshaped reserve: any size and any alignment pattern.
               issue(OP_RESERVE, SIZE_BITS'($urandom), ALIGN_BITS'($urandom),
                     {$urandom, $urandom});
            end else if (roll < 55) begin
               span = ring_now >> (hoard ? 7 : 2);
               if (span == '0)
                  span = SIZE_BITS'(1);
               align = ($urandom_range(0, 99) < 20) ? ALIGN_BITS'(1) << $urandom_range(5, 16)
                                                    : ALIGN_BITS'(1) << $urandom_range(0, 4);
               issue(OP_RESERVE, SIZE_BITS'($urandom_range(1, span)), align,
                     {$urandom, $urandom});
            end else if (roll < 75) begin
               fence_queued = fence_queued + FENCE_BITS'(1);
               issue(OP_QUEUE, SIZE_BITS'($urandom), ALIGN_BITS'($urandom), fence_queued);
            end else begin
               // Mostly completions that creep toward the last queued fence; now and then
               // zero, all ones or an arbitrary value.
               if ($urandom_range(0, 9) == 0) begin
                  case ($urandom_range(0, 2))
                     0:       fence_pick = '0;
                     1:       fence_pick = '1;
                     default: fence_pick = {$urandom, $urandom};
                  endcase
               end else begin
                  if (fence_queued - fence_done > FENCE_BITS'(3))
                     fence_done = fence_done + FENCE_BITS'($urandom_range(1, 3));
                  else
                     fence_done = fence_queued;
                  fence_pick = fence_done;
               end
               issue(OP_FENCE, SIZE_BITS'($urandom), ALIGN_BITS'($urandom), fence_pick);
            end
         end
      end

      // Drain, then allow for a full checkpoint sweep before the verdict.
      settle();
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("fenced_ring_buffer_allocator: match");
      else
         $display("fenced_ring_buffer_allocator: mismatch");
      $finish;
   end

endmodule
